### rtl/vmt_pkg.sv
// Package for the VLAN membership table.
// Holds the command and response transaction types, the operation and status codes,
// the controller state encoding and the control structs. No dependencies.
package vmt_pkg;

  localparam int unsigned VLAN_ID_W = 12;
  localparam int unsigned PORT_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned PORT_COUNT_DEF = 32;
  localparam int unsigned VLAN_COUNT_DEF = 4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE      = 3'd0,
    KIND_DESTROY     = 3'd1,
    KIND_DESTROY_ALL = 3'd2,
    KIND_PORT_ADD    = 3'd3,
    KIND_PORT_REMOVE = 3'd4,
    KIND_PORT_GET    = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_PARAM     = 2'd1,
    STATUS_EXISTS    = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [VLAN_ID_W-1:0] vlan_id;
    logic [PORT_W-1:0]    member_ports;
    logic [PORT_W-1:0]    untagged_ports;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   member_ports_out;
    logic [PORT_W-1:0]   untagged_ports_out;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the request and read its table entry
    logic exec;     // execute the latched command and load the response
    logic sweep;    // clear one table entry at the sweep pointer
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;    // response register can take a result this cycle
    logic cmd_all;     // latched command is destroy all
    logic sweep_last;  // sweep pointer is at the last entry
  } ctl_stat_t;

endpackage

### rtl/vlan_membership_table.sv
// Top level of the VLAN membership table: controller plus datapath.
// Depends on vmt_pkg, vmt_ctrl and vmt_datapath.
//
// On acceptance a command is latched and its entry is read from the single-port table memory;
// in the execute step the entry is written back and the response register is loaded, and only
// then can the next command be accepted. The result may wait for rsp_ready_i while the next
// command is already accepted. Execution stalls if the previous response is still pending.
// After reset the table runs a clearing pass over all VLAN_COUNT entries (4096 by default)
// with req_ready_o low, and destroy all gives its result at once, then runs the same
// clearing pass before the next command.
module vlan_membership_table #(
  parameter int unsigned PORT_COUNT = vmt_pkg::PORT_COUNT_DEF,
  parameter int unsigned VLAN_COUNT = vmt_pkg::VLAN_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  vmt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output vmt_pkg::rsp_t rsp_o
);

  vmt_pkg::ctl_cmd_t  ctl;
  vmt_pkg::ctl_stat_t stat;

  vmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  vmt_datapath #(
    .PORT_COUNT (PORT_COUNT),
    .VLAN_COUNT (VLAN_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted command is executed before another one is taken.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("command accepted while the previous one is still executing");

  // A result is only loaded when the response register is free.
  a_exec_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.exec |-> stat.out_free)
    else $error("response register overwritten before it was taken");

  // No command is accepted while the table is being cleared.
  a_sweep_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.sweep |-> !req_ready_o && !ctl.exec)
    else $error("command activity during the clearing sweep");
`endif

endmodule

### rtl/vmt_datapath.sv
// Datapath of the VLAN membership table: command register, entry memory,
// read-modify-write logic, clearing sweep pointer and response register.
// Depends on vmt_pkg.
module vmt_datapath #(
  parameter int unsigned PORT_COUNT = vmt_pkg::PORT_COUNT_DEF,
  parameter int unsigned VLAN_COUNT = vmt_pkg::VLAN_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vmt_pkg::req_t     req_i,
  input  vmt_pkg::ctl_cmd_t ctl_i,
  output vmt_pkg::ctl_stat_t stat_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output vmt_pkg::rsp_t     rsp_o
);

  localparam int unsigned PW = (PORT_COUNT < vmt_pkg::PORT_W) ? PORT_COUNT : vmt_pkg::PORT_W;
  localparam int unsigned EW = 1 + 2 * PW;
  localparam int unsigned AW = (VLAN_COUNT > 1) ? $clog2(VLAN_COUNT) : 1;

  // Entry layout: valid on top, then member bitmap, then untagged bitmap.
  logic [EW-1:0] mem_q [VLAN_COUNT];

  vmt_pkg::req_t cmd_q;
  logic [EW-1:0] rdata_q;
  logic [AW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic          rsp_valid_q;
  vmt_pkg::rsp_t rsp_q;

  logic          in_range;
  logic          present;
  logic [PW-1:0] cur_mem, cur_unt, arg_mem, arg_unt;
  logic          ex_we;
  logic [EW-1:0] ex_wdata;
  vmt_pkg::rsp_t ex_rsp;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= req_i;
      rdata_q <= mem_q[req_i.vlan_id[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  assign in_range = (cmd_q.vlan_id != '0) && (32'(cmd_q.vlan_id) < VLAN_COUNT);
  assign present  = in_range && rdata_q[EW-1];
  assign cur_mem  = rdata_q[2*PW-1:PW];
  assign cur_unt  = rdata_q[PW-1:0];
  assign arg_mem  = cmd_q.member_ports[PW-1:0];
  assign arg_unt  = cmd_q.untagged_ports[PW-1:0];

  always_comb begin
    ex_we    = 1'b0;
    ex_wdata = rdata_q;
    ex_rsp   = '0;
    ex_rsp.status = vmt_pkg::STATUS_OK;
    unique case (cmd_q.kind)
      vmt_pkg::KIND_CREATE: begin
        if (!in_range) begin
          ex_rsp.status = vmt_pkg::STATUS_PARAM;
        end else if (rdata_q[EW-1]) begin
          ex_rsp.status = vmt_pkg::STATUS_EXISTS;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {1'b1, {(2*PW){1'b0}}};
        end
      end
      vmt_pkg::KIND_DESTROY: begin
        if (!present) begin
          ex_rsp.status = vmt_pkg::STATUS_NOT_FOUND;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {1'b0, cur_mem, cur_unt};
        end
      end
      vmt_pkg::KIND_DESTROY_ALL: begin
        // The valid bits are cleared by the sweep that follows.
        ex_rsp.status = vmt_pkg::STATUS_OK;
      end
      vmt_pkg::KIND_PORT_ADD: begin
        if (!present) begin
          ex_rsp.status = vmt_pkg::STATUS_NOT_FOUND;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {1'b1, cur_mem | arg_mem, cur_unt | arg_unt};
        end
      end
      vmt_pkg::KIND_PORT_REMOVE: begin
        if (!present) begin
          ex_rsp.status = vmt_pkg::STATUS_NOT_FOUND;
        end else begin
          ex_we    = 1'b1;
          ex_wdata = {1'b1, cur_mem & ~arg_mem, cur_unt & ~arg_mem};
        end
      end
      vmt_pkg::KIND_PORT_GET: begin
        if (!present) begin
          ex_rsp.status = vmt_pkg::STATUS_NOT_FOUND;
        end else begin
          ex_rsp.member_ports_out   = vmt_pkg::PORT_W'(cur_mem);
          ex_rsp.untagged_ports_out = vmt_pkg::PORT_W'(cur_unt);
        end
      end
      default: begin
        ex_rsp.status = vmt_pkg::STATUS_PARAM;
      end
    endcase
  end

  // The sweep writes whole entries to zero; bitmaps of an invalid entry are never read.
  assign we    = ctl_i.sweep || (ctl_i.exec && ex_we);
  assign waddr = ctl_i.sweep ? sweep_cnt_q : cmd_q.vlan_id[AW-1:0];
  assign wdata = ctl_i.sweep ? '0 : ex_wdata;

  always_comb begin
    sweep_cnt_d = sweep_cnt_q;
    if (ctl_i.sweep) begin
      sweep_cnt_d = stat_o.sweep_last ? '0 : sweep_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      sweep_cnt_q <= sweep_cnt_d;
      if (ctl_i.exec) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      rsp_q <= ex_rsp;
    end
  end

  assign stat_o.out_free   = !rsp_valid_q || rsp_ready_i;
  assign stat_o.cmd_all    = (cmd_q.kind == vmt_pkg::KIND_DESTROY_ALL);
  assign stat_o.sweep_last = (sweep_cnt_q == AW'(VLAN_COUNT - 1));

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### rtl/vmt_ctrl.sv
// Controller of the VLAN membership table: sequences the clearing sweep,
// request capture and command execution. Depends on vmt_pkg.
module vmt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  vmt_pkg::ctl_stat_t stat_i,
  output vmt_pkg::ctl_cmd_t  ctl_o
);

  vmt_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      vmt_pkg::ST_SWEEP: begin
        ctl_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = vmt_pkg::ST_IDLE;
        end
      end
      vmt_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = vmt_pkg::ST_EXEC;
        end
      end
      vmt_pkg::ST_EXEC: begin
        // Wait here while the previous response has not been taken.
        if (stat_i.out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = stat_i.cmd_all ? vmt_pkg::ST_SWEEP : vmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vmt_pkg::ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vmt_pkg::ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == vmt_pkg::ST_IDLE);

endmodule
